### sv/atids_pkg.sv
// Shared types and constants for the ordered word list block.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package atids_pkg;

  // Default list depth
  localparam int unsigned DEPTH_DEF = 128;

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_LSRCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_BSRCH  = 3'd4;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd5;
  localparam logic [OP_W-1:0] OP_READ   = 3'd6;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd2;

  // Datapath commands issued by the controller
  typedef enum logic [4:0] {
    DC_IDLE,
    DC_INIT,
    DC_INS_CHK,
    DC_INS_RD,
    DC_INS_WR,
    DC_INS_PUT,
    DC_DEL_CHK,
    DC_DEL_RD,
    DC_DEL_WR,
    DC_DEL_END,
    DC_LIN_CHK,
    DC_LIN_RD,
    DC_LIN_CMP,
    DC_BIN_CHK,
    DC_BIN_RD,
    DC_BIN_CMP,
    DC_SRT_CHK,
    DC_SRT_RDA,
    DC_SRT_RDB,
    DC_SRT_CMP,
    DC_SRT_WRA,
    DC_SRT_WRB,
    DC_RD_RD,
    DC_RD_CAP,
    DC_FINISH
  } dp_cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;  // capture the incoming transaction
    dp_cmd_e cmd;
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            ins_bad;
    logic            pos_bad;
    logic            ins_done;
    logic            del_done;
    logic            lin_done;
    logic            bin_done;
    logic            hit;
    logic            gt;
    logic            pass_end;
    logic            swapped;
    logic            out_free;
  } dp_stat_t;

endpackage

### sv/atids_if.sv
// Handshake channel interfaces for the ordered word list block.
// Depends on atids_pkg for field widths.
`timescale 1ns / 1ps

interface atids_in_if;
  logic                              valid;
  logic                              ready;
  logic [atids_pkg::OP_W-1:0]        opcode;
  logic [atids_pkg::POS_W-1:0]       position;
  logic signed [atids_pkg::WORD_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface atids_out_if;
  logic                                valid;
  logic                                ready;
  logic [atids_pkg::STAT_W-1:0]        status;
  logic                                found;
  logic signed [atids_pkg::WORD_W-1:0] read_value;
  logic [atids_pkg::COUNT_W-1:0]       entry_count;

  modport source (output valid, status, found, read_value, entry_count, input ready);
  modport sink   (input valid, status, found, read_value, entry_count, output ready);
endinterface

### sv/atids_ctrl.sv
// Sequencing state machine for the ordered word list block.
// Depends on atids_pkg; drives atids_dp through command and status structs.
`timescale 1ns / 1ps

module atids_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  atids_pkg::dp_stat_t st_i,
  output atids_pkg::dp_ctl_t  ctl_o
);
  import atids_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT    = 5'd1;
  localparam logic [4:0] S_INS_CHK = 5'd2;
  localparam logic [4:0] S_INS_RD  = 5'd3;
  localparam logic [4:0] S_INS_WR  = 5'd4;
  localparam logic [4:0] S_INS_PUT = 5'd5;
  localparam logic [4:0] S_DEL_CHK = 5'd6;
  localparam logic [4:0] S_DEL_RD  = 5'd7;
  localparam logic [4:0] S_DEL_WR  = 5'd8;
  localparam logic [4:0] S_DEL_END = 5'd9;
  localparam logic [4:0] S_LIN_CHK = 5'd10;
  localparam logic [4:0] S_LIN_RD  = 5'd11;
  localparam logic [4:0] S_LIN_CMP = 5'd12;
  localparam logic [4:0] S_BIN_CHK = 5'd13;
  localparam logic [4:0] S_BIN_RD  = 5'd14;
  localparam logic [4:0] S_BIN_CMP = 5'd15;
  localparam logic [4:0] S_SRT_CHK = 5'd16;
  localparam logic [4:0] S_SRT_RDA = 5'd17;
  localparam logic [4:0] S_SRT_RDB = 5'd18;
  localparam logic [4:0] S_SRT_CMP = 5'd19;
  localparam logic [4:0] S_SRT_WRA = 5'd20;
  localparam logic [4:0] S_SRT_WRB = 5'd21;
  localparam logic [4:0] S_RD_RD   = 5'd22;
  localparam logic [4:0] S_RD_CAP  = 5'd23;
  localparam logic [4:0] S_FINISH  = 5'd24;

  logic [4:0] state_q, state_d;
  dp_cmd_e    cmd;

  assign in_ready_o = (state_q == S_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd     = DC_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_INIT;
      end
      S_INIT: begin
        cmd = DC_INIT;
        unique case (st_i.op)
          OP_INSERT: state_d = (st_i.full || st_i.ins_bad) ? S_FINISH : S_INS_CHK;
          OP_DELETE: state_d = st_i.pos_bad ? S_FINISH : S_DEL_CHK;
          OP_LSRCH:  state_d = S_LIN_CHK;
          OP_BSRCH:  state_d = S_BIN_CHK;
          OP_SORT:   state_d = S_SRT_CHK;
          OP_READ:   state_d = st_i.pos_bad ? S_FINISH : S_RD_RD;
          default:   state_d = S_FINISH;
        endcase
      end
      S_INS_CHK: begin
        cmd     = DC_INS_CHK;
        state_d = st_i.ins_done ? S_INS_PUT : S_INS_RD;
      end
      S_INS_RD: begin
        cmd     = DC_INS_RD;
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        cmd     = DC_INS_WR;
        state_d = S_INS_CHK;
      end
      S_INS_PUT: begin
        cmd     = DC_INS_PUT;
        state_d = S_FINISH;
      end
      S_DEL_CHK: begin
        cmd     = DC_DEL_CHK;
        state_d = st_i.del_done ? S_DEL_END : S_DEL_RD;
      end
      S_DEL_RD: begin
        cmd     = DC_DEL_RD;
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd     = DC_DEL_WR;
        state_d = S_DEL_CHK;
      end
      S_DEL_END: begin
        cmd     = DC_DEL_END;
        state_d = S_FINISH;
      end
      S_LIN_CHK: begin
        cmd     = DC_LIN_CHK;
        state_d = st_i.lin_done ? S_FINISH : S_LIN_RD;
      end
      S_LIN_RD: begin
        cmd     = DC_LIN_RD;
        state_d = S_LIN_CMP;
      end
      S_LIN_CMP: begin
        cmd     = DC_LIN_CMP;
        state_d = st_i.hit ? S_FINISH : S_LIN_CHK;
      end
      S_BIN_CHK: begin
        cmd     = DC_BIN_CHK;
        state_d = st_i.bin_done ? S_FINISH : S_BIN_RD;
      end
      S_BIN_RD: begin
        cmd     = DC_BIN_RD;
        state_d = S_BIN_CMP;
      end
      S_BIN_CMP: begin
        cmd     = DC_BIN_CMP;
        state_d = st_i.hit ? S_FINISH : S_BIN_CHK;
      end
      S_SRT_CHK: begin
        cmd = DC_SRT_CHK;
        priority if (st_i.pass_end && !st_i.swapped) state_d = S_FINISH;
        else if (st_i.pass_end)                      state_d = S_SRT_CHK;
        else                                         state_d = S_SRT_RDA;
      end
      S_SRT_RDA: begin
        cmd     = DC_SRT_RDA;
        state_d = S_SRT_RDB;
      end
      S_SRT_RDB: begin
        cmd     = DC_SRT_RDB;
        state_d = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd     = DC_SRT_CMP;
        state_d = st_i.gt ? S_SRT_WRA : S_SRT_CHK;
      end
      S_SRT_WRA: begin
        cmd     = DC_SRT_WRA;
        state_d = S_SRT_WRB;
      end
      S_SRT_WRB: begin
        cmd     = DC_SRT_WRB;
        state_d = S_SRT_CHK;
      end
      S_RD_RD: begin
        cmd     = DC_RD_RD;
        state_d = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd     = DC_RD_CAP;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd = DC_FINISH;
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ctl_o.load = in_ready_o && in_valid_i;
  assign ctl_o.cmd  = cmd;

endmodule

### sv/atids_dp.sv
// Datapath for the ordered word list: entry memory, count, indices and result register.
// Depends on atids_pkg; commanded by atids_ctrl.
`timescale 1ns / 1ps

module atids_dp #(
  parameter int unsigned DEPTH = atids_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [atids_pkg::OP_W-1:0]          opcode_i,
  input  logic [atids_pkg::POS_W-1:0]         position_i,
  input  logic signed [atids_pkg::WORD_W-1:0] value_i,
  input  atids_pkg::dp_ctl_t                  ctl_i,
  output atids_pkg::dp_stat_t                 st_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [atids_pkg::STAT_W-1:0]        status_o,
  output logic                                found_o,
  output logic signed [atids_pkg::WORD_W-1:0] read_value_o,
  output logic [atids_pkg::COUNT_W-1:0]       entry_count_o
);
  import atids_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Entry memory
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Operation registers
  logic [OP_W-1:0]     op_q;
  logic [POS_W-1:0]    pos_q;
  logic [WORD_W-1:0]   key_q;
  logic [WORD_W-1:0]   a_q;
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       idx_q;
  logic signed [CW:0]  lo_q, hi_q;
  logic                swp_q;
  logic                found_q;
  logic [STAT_W-1:0]   stat_q;
  logic [WORD_W-1:0]   rdv_q;

  // Result register
  logic                out_valid_q;
  logic [STAT_W-1:0]   out_stat_q;
  logic                out_found_q;
  logic [WORD_W-1:0]   out_rdv_q;
  logic [COUNT_W-1:0]  out_cnt_q;

  logic [CMPW-1:0]     pos_ext, cnt_ext;
  logic [CW-1:0]       pos0, idx_inc, idx_dec;
  logic [CW:0]         idx_nxt_w;
  logic signed [CW:0]  mid_s;
  logic                out_load;
  logic                hit;

  // Checks and index arithmetic
  assign pos_ext   = CMPW'(pos_q);
  assign cnt_ext   = CMPW'(cnt_q);
  assign pos0      = CW'(pos_ext - CMPW'(1));
  assign idx_inc   = idx_q + CW'(1);
  assign idx_dec   = idx_q - CW'(1);
  assign idx_nxt_w = {1'b0, idx_q} + (CW + 1)'(1);
  assign mid_s     = lo_q + ((hi_q - lo_q) >>> 1);
  assign hit       = (rdata_q == key_q);
  assign out_load  = (ctl_i.cmd == DC_FINISH) && st_o.out_free;

  assign st_o.op       = op_q;
  assign st_o.full     = (cnt_q == CW'(DEPTH));
  assign st_o.ins_bad  = (pos_q == '0) || (pos_ext > cnt_ext + CMPW'(1));
  assign st_o.pos_bad  = (pos_q == '0) || (pos_ext > cnt_ext);
  assign st_o.ins_done = (idx_q == pos0);
  assign st_o.del_done = (idx_nxt_w >= {1'b0, cnt_q});
  assign st_o.lin_done = (idx_q >= cnt_q);
  assign st_o.bin_done = (lo_q > hi_q);
  assign st_o.hit      = hit;
  assign st_o.gt       = ($signed(a_q) > $signed(rdata_q));
  assign st_o.pass_end = (idx_nxt_w >= {1'b0, cnt_q});
  assign st_o.swapped  = swp_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = rdata_q;
    unique case (ctl_i.cmd)
      DC_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_dec[AW-1:0];
      end
      DC_DEL_RD, DC_SRT_RDB: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc[AW-1:0];
      end
      DC_LIN_RD, DC_SRT_RDA, DC_RD_RD: begin
        rd_en = 1'b1;
      end
      DC_BIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid_s[AW-1:0];
      end
      DC_INS_WR, DC_DEL_WR, DC_SRT_WRA: begin
        wr_en = 1'b1;
      end
      DC_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos0[AW-1:0];
        wr_data = key_q;
      end
      DC_SRT_WRB: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc[AW-1:0];
        wr_data = a_q;
      end
      default: ;
    endcase
  end

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Live count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (ctl_i.cmd == DC_INIT && op_q == OP_CLEAR) cnt_q <= '0;
      else if (ctl_i.cmd == DC_INS_PUT)             cnt_q <= cnt_q + CW'(1);
      else if (ctl_i.cmd == DC_DEL_END)             cnt_q <= cnt_q - CW'(1);
    end
  end

  // Transaction capture and working registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= opcode_i;
      pos_q <= position_i;
      key_q <= value_i;
    end
    unique case (ctl_i.cmd)
      DC_INIT: begin
        found_q <= 1'b0;
        rdv_q   <= '0;
        swp_q   <= 1'b0;
        lo_q    <= '0;
        hi_q    <= $signed({1'b0, cnt_q}) - $signed((CW + 1)'(1));
        unique case (op_q)
          OP_INSERT: begin
            idx_q <= cnt_q;
            priority if (st_o.full) stat_q <= ST_FULL;
            else if (st_o.ins_bad)  stat_q <= ST_BAD_POS;
            else                    stat_q <= ST_OK;
          end
          OP_DELETE, OP_READ: begin
            idx_q  <= pos0;
            stat_q <= st_o.pos_bad ? ST_BAD_POS : ST_OK;
          end
          default: begin
            idx_q  <= '0;
            stat_q <= ST_OK;
          end
        endcase
      end
      DC_INS_WR:               idx_q <= idx_dec;
      DC_DEL_WR, DC_LIN_RD:    idx_q <= idx_inc;
      DC_LIN_CMP: begin
        if (hit) found_q <= 1'b1;
      end
      DC_BIN_RD:               idx_q <= mid_s[CW-1:0];
      DC_BIN_CMP: begin
        priority if (hit) found_q <= 1'b1;
        else if ($signed(rdata_q) < $signed(key_q)) lo_q <= $signed({1'b0, idx_inc});
        else hi_q <= $signed({1'b0, idx_q}) - $signed((CW + 1)'(1));
      end
      DC_SRT_CHK: begin
        // Start a fresh pass while the last one still moved something
        if (st_o.pass_end && swp_q) begin
          idx_q <= '0;
          swp_q <= 1'b0;
        end
      end
      DC_SRT_RDB:              a_q <= rdata_q;
      DC_SRT_CMP: begin
        if (!st_o.gt) idx_q <= idx_inc;
      end
      DC_SRT_WRA:              swp_q <= 1'b1;
      DC_SRT_WRB:              idx_q <= idx_inc;
      DC_RD_CAP:               rdv_q <= rdata_q;
      default: ;
    endcase
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q  <= stat_q;
      out_found_q <= found_q;
      out_rdv_q   <= rdv_q;
      out_cnt_q   <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign found_o       = out_found_q;
  assign read_value_o  = out_rdv_q;
  assign entry_count_o = out_cnt_q;

endmodule

### sv/array_table_insert_delete_search_sort.sv
// Ordered list of signed words: clear, insert, delete, searches, sort, read.
// Insert and delete shift the entries one by one, linear search scans them in order, binary
// search probes midpoints, and sort runs bubble passes (up to count passes) over the entry memory.
// One transaction at a time: a new one is taken only in the idle state, after the last result loads.
// Reset: count zero, result register empty; entry memory contents undefined, no clear pass.
`timescale 1ns / 1ps

module array_table_insert_delete_search_sort #(
  parameter int unsigned DEPTH = atids_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atids_in_if.sink    in_i,
  atids_out_if.source out_o
);
  import atids_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t st;

  // Sequencer
  atids_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .ctl_o      (ctl)
  );

  // Storage and arithmetic
  atids_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (in_i.opcode),
    .position_i    (in_i.position),
    .value_i       (in_i.value),
    .ctl_i         (ctl),
    .st_o          (st),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .found_o       (out_o.found),
    .read_value_o  (out_o.read_value),
    .entry_count_o (out_o.entry_count)
  );

endmodule

### bench/array_table_insert_delete_search_sort_tb.sv
// Testbench for the ordered word list block: directed corner cases, then random operations.
// Depends on atids_pkg, atids_if and the array_table_insert_delete_search_sort top level.
`timescale 1ns / 1ps

module array_table_insert_delete_search_sort_tb;
  import atids_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned RANDOM_ITEMS = 740;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [WORD_W-1:0] read_value;
    logic [COUNT_W-1:0]       entry_count;
  } list_result_t;

  // Tracks the list contents and the queue of outstanding results
  class list_scoreboard;
    logic signed [WORD_W-1:0] words[LIST_DEPTH];
    int unsigned              live;
    list_result_t             pending[$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              op_seen[8];

    function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [WORD_W-1:0] val);
      list_result_t r;
      logic signed [WORD_W-1:0] key;
      int lo, hi, mid, j;
      r = '0;
      op_seen[op]++;
      case (op)
        OP_CLEAR: live = 0;
        OP_INSERT: begin
          if (live >= LIST_DEPTH) r.status = ST_FULL;
          else if (pos < 1 || pos > live + 1) r.status = ST_BAD_POS;
          else begin
            for (int i = live; i >= pos; i--) words[i] = words[i-1];
            words[pos-1] = val;
            live++;
          end
        end
        OP_DELETE: begin
          if (pos < 1 || pos > live) r.status = ST_BAD_POS;
          else begin
            for (int i = pos - 1; i + 1 < live; i++) words[i] = words[i+1];
            live--;
          end
        end
        OP_LSRCH: begin
          for (int i = 0; i < live; i++) if (words[i] == val) r.found = 1'b1;
        end
        OP_BSRCH: begin
          lo = 0;
          hi = int'(live) - 1;
          while (lo <= hi && !r.found) begin
            mid = lo + (hi - lo) / 2;
            if (words[mid] == val) r.found = 1'b1;
            else if (words[mid] < val) lo = mid + 1;
            else hi = mid - 1;
          end
        end
        OP_SORT: begin
          for (int i = 1; i < live; i++) begin
            key = words[i];
            j = i;
            while (j > 0 && words[j-1] > key) begin
              words[j] = words[j-1];
              j--;
            end
            words[j] = key;
          end
        end
        OP_READ: begin
          if (pos < 1 || pos > live) r.status = ST_BAD_POS;
          else r.read_value = words[pos-1];
        end
        default: ;
      endcase
      r.entry_count = live[COUNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d, got %0d", exp_r.found, got.found);
        errors++;
      end
      if (got.read_value !== exp_r.read_value) begin
        $error("read_value: expected %0d, got %0d", exp_r.read_value, got.read_value);
        errors++;
      end
      if (got.entry_count !== exp_r.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_r.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  list_scoreboard sb;

  atids_in_if  in_ch();
  atids_out_if out_ch();

  array_table_insert_delete_search_sort #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one transaction and wait for it to be taken, with an optional gap after
  task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                         logic signed [WORD_W-1:0] val);
    int unsigned gap;
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.position <= pos;
    in_ch.value    <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(op, pos, val);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Value pool: small range gives duplicates, the rest spans the whole word
  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, sometimes any 8-bit value
  function automatic logic [POS_W-1:0] pick_pos(int unsigned span);
    if ($urandom_range(0, 9) == 0 || span == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(1, span));
  endfunction

  // Result side: random stalls, one long hold-off
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.status, out_ch.found, out_ch.read_value,
                          out_ch.entry_count});
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned r, start_sent;
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_CLEAR;
    in_ch.position = '0;
    in_ch.value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list errors, extremes, every operation, unused opcode
    send_op(OP_READ, 8'd1, 0);
    send_op(OP_DELETE, 8'd1, 0);
    send_op(OP_INSERT, 8'd0, 5);
    send_op(OP_INSERT, 8'd2, 5);
    send_op(OP_INSERT, 8'd1, 32'sh7fffffff);
    send_op(OP_INSERT, 8'd1, 32'sh80000000);
    send_op(OP_INSERT, 8'd2, -1);
    send_op(OP_INSERT, 8'd4, 0);
    send_op(OP_INSERT, 8'd6, 9);
    send_op(OP_INSERT, 8'd255, 9);
    send_op(OP_READ, 8'd3, 0);
    send_op(OP_READ, 8'd5, 0);
    send_op(OP_LSRCH, 8'd0, 32'sh7fffffff);
    send_op(OP_LSRCH, 8'd255, 17);
    send_op(OP_BSRCH, 8'd0, 32'sh7fffffff);
    send_op(OP_SORT, 8'd77, 0);
    send_op(OP_BSRCH, 8'd0, -1);
    send_op(OP_BSRCH, 8'd0, 32'sh80000000);
    send_op(OP_BSRCH, 8'd0, 3);
    send_op(OP_UNUSED, 8'd255, 32'shffffffff);
    send_op(OP_DELETE, 8'd2, 0);
    send_op(OP_DELETE, 8'd4, 0);
    send_op(OP_READ, 8'd0, 0);
    send_op(OP_CLEAR, 8'd0, 0);

    // Fill to the top, then a rejected insert and a full-length sort
    for (int i = 0; i < LIST_DEPTH; i++) send_op(OP_INSERT, POS_W'(i + 1), $urandom);
    send_op(OP_INSERT, 8'd1, 1);
    send_op(OP_READ, 8'd128, 0);
    send_op(OP_READ, 8'd129, 0);
    send_op(OP_SORT, 8'd0, 0);
    send_op(OP_BSRCH, 8'd0, sb.words[$urandom_range(0, LIST_DEPTH - 1)]);
    send_op(OP_DELETE, 8'd128, 0);
    send_op(OP_CLEAR, 8'd0, 0);

    // Random part: lists kept short so sorts and walks stay cheap
    start_sent = sent;
    while (sent - start_sent < RANDOM_ITEMS) begin
      if (sent - start_sent == 300) hold_off = 1'b1;
      if (sent - start_sent > 640) calm = 1'b1;
      r = $urandom_range(0, 99);
      if (sb.live > 20 && r < 35) r = r + 35;
      if (r < 35)
        send_op(OP_INSERT, pick_pos(sb.live + 1), pick_value());
      else if (r < 55)
        send_op(OP_DELETE, pick_pos(sb.live), 0);
      else if (r < 70)
        send_op(OP_READ, pick_pos(sb.live), 0);
      else if (r < 88)
        send_op($urandom_range(0, 1) ? OP_LSRCH : OP_BSRCH, POS_W'($urandom),
                (sb.live > 0 && $urandom_range(0, 1)) ?
                  sb.words[$urandom_range(0, sb.live - 1)] : pick_value());
      else if (r < 95)
        send_op(OP_SORT, POS_W'($urandom), $urandom);
      else if (r < 98)
        send_op(OP_CLEAR, POS_W'($urandom), $urandom);
      else
        send_op(OP_UNUSED, POS_W'($urandom), $urandom);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Ran %0d transactions, %0d results checked (inserts %0d, sorts %0d, searches %0d).",
             sent, sb.checked, sb.op_seen[OP_INSERT], sb.op_seen[OP_SORT],
             sb.op_seen[OP_LSRCH] + sb.op_seen[OP_BSRCH]);
    $display("Covered full list, bad positions, unused opcode and a long result stall.");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
